// File: sv/sdz_pkg.sv
// Shared constants and types for the stick dead-zone scaler.
`timescale 1ns / 1ps
`default_nettype none
package sdz_pkg;

  localparam int FRAC_BITS = 14;
  localparam int AX_W      = 16;
  localparam int CFG_W     = 15;
  localparam int IDX_W     = 2;
  localparam int SQ_W      = 2 * AX_W;
  localparam int RT_W      = SQ_W / 2;
  localparam int RREM_W    = RT_W + 4;
  localparam int S_W       = FRAC_BITS + 1;
  localparam int Q_W       = S_W;
  localparam int PROD_W    = AX_W + S_W;
  localparam int CREM_W    = CFG_W + 1;
  localparam int DREM_W    = RT_W + 1;
  localparam int LANE_LAT  = 3 + FRAC_BITS + Q_W;
  localparam int TAP       = 1 + RT_W;
  localparam int META_LEN  = 2 + RT_W + LANE_LAT;

  localparam logic [S_W-1:0]   ONE_S       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CFG_W-1:0] ONE_C       = CFG_W'(ONE_S);
  localparam logic [CFG_W-1:0] DZ_LOW_RST  = CFG_W'(4096);
  localparam logic [CFG_W-1:0] UPPER_RST   = CFG_W'(16384);

  typedef enum logic [IDX_W-1:0] {
    REG_DZ_LOW = 2'd0,
    REG_UPPER  = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_BOOL = 2'd0,
    KIND_1D   = 2'd1,
    KIND_2D   = 2'd2,
    KIND_3D   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic                    radial;
    logic signed [AX_W-1:0]  x;
    logic signed [AX_W-1:0]  y;
    logic signed [AX_W-1:0]  z;
  } item_t;

endpackage
`default_nettype wire

// File: sv/sdz_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module sdz_sqrt
  import sdz_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic [SQ_W-1:0] rad_i,
  output logic      [RT_W-1:0] root_o
);

  logic [SQ_W-1:0]   n_q   [RT_W];
  logic [RREM_W-1:0] rem_q [RT_W];
  logic [RT_W-1:0]   r_q   [RT_W];
  logic [SQ_W-1:0]   n_s   [RT_W+1];
  logic [RREM_W-1:0] rem_s [RT_W+1];
  logic [RT_W-1:0]   r_s   [RT_W+1];

  assign n_s[0]   = rad_i;
  assign rem_s[0] = '0;
  assign r_s[0]   = '0;

  for (genvar i = 0; i < RT_W; i++) begin : g_stage
    logic [RREM_W-1:0] sh;
    logic [RREM_W-1:0] trial;

    assign n_s[i+1]   = n_q[i];
    assign rem_s[i+1] = rem_q[i];
    assign r_s[i+1]   = r_q[i];

    always_comb begin
      sh    = {rem_s[i][RREM_W-3:0], n_s[i][SQ_W-1-2*i -: 2]};
      trial = RREM_W'({r_s[i], 2'b01});
    end

    always_ff @(posedge clk_i) begin
      n_q[i] <= n_s[i];
      if (sh >= trial) begin
        rem_q[i] <= sh - trial;
        r_q[i]   <= {r_s[i][RT_W-2:0], 1'b1};
      end else begin
        rem_q[i] <= sh;
        r_q[i]   <= {r_s[i][RT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = r_s[RT_W];

endmodule
`default_nettype wire

// File: sv/sdz_lane.sv
// One axis lane: dead-zone curve, radial scaling and sign restore.
`timescale 1ns / 1ps
`default_nettype none
module sdz_lane
  import sdz_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   radial_i,
  input  wire logic signed [AX_W-1:0] c_i,
  input  wire logic [RT_W-1:0]        mag_i,
  input  wire logic [CFG_W-1:0]       lower_i,
  input  wire logic [CFG_W-1:0]       upper_i,
  output logic signed [AX_W-1:0]      res_o
);

  typedef struct packed {
    logic                   radial;
    logic                   zero;
    logic                   full;
    logic signed [AX_W-1:0] c;
    logic [RT_W-1:0]        mag;
    logic [CFG_W-1:0]       d;
    logic [CREM_W-1:0]      rem;
    logic [FRAC_BITS-1:0]   q;
  } cv_t;

  typedef struct packed {
    logic                   radial;
    logic signed [AX_W-1:0] c;
    logic [S_W-1:0]         s;
    logic [RT_W-1:0]        mag;
    logic [PROD_W-1:0]      p;
    logic [DREM_W-1:0]      rem;
    logic [Q_W-1:0]         q;
  } dv_t;

  cv_t cv_q [FRAC_BITS+1];
  dv_t dv_q [Q_W+1];
  logic signed [AX_W-1:0] res_q;

  // magnitude select and threshold checks
  logic [AX_W-1:0]  abs_a, m_a, excess_a;
  logic [CFG_W-1:0] d_a;

  always_comb begin
    abs_a    = c_i[AX_W-1] ? AX_W'(-c_i) : AX_W'(c_i);
    m_a      = radial_i ? AX_W'(mag_i) : abs_a;
    excess_a = m_a - AX_W'(lower_i);
    d_a      = upper_i - lower_i;
  end

  always_ff @(posedge clk_i) begin
    cv_q[0].radial <= radial_i;
    cv_q[0].zero   <= m_a <= AX_W'(lower_i);
    cv_q[0].full   <= (upper_i <= lower_i) || (excess_a >= AX_W'(d_a));
    cv_q[0].c      <= c_i;
    cv_q[0].mag    <= mag_i;
    cv_q[0].d      <= d_a;
    cv_q[0].rem    <= CREM_W'(excess_a);
    cv_q[0].q      <= '0;
  end

  // restoring division of excess * ONE by (upper - lower)
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_curve
    logic [CREM_W-1:0] sh;
    assign sh = {cv_q[j].rem[CREM_W-2:0], 1'b0};

    always_ff @(posedge clk_i) begin
      cv_q[j+1].radial <= cv_q[j].radial;
      cv_q[j+1].zero   <= cv_q[j].zero;
      cv_q[j+1].full   <= cv_q[j].full;
      cv_q[j+1].c      <= cv_q[j].c;
      cv_q[j+1].mag    <= cv_q[j].mag;
      cv_q[j+1].d      <= cv_q[j].d;
      if (sh >= {1'b0, cv_q[j].d}) begin
        cv_q[j+1].rem <= sh - {1'b0, cv_q[j].d};
        cv_q[j+1].q   <= {cv_q[j].q[FRAC_BITS-2:0], 1'b1};
      end else begin
        cv_q[j+1].rem <= sh;
        cv_q[j+1].q   <= {cv_q[j].q[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  logic [S_W-1:0]    s_m;
  logic [AX_W-1:0]   abs_m;
  logic [PROD_W-1:0] p_m;

  always_comb begin
    priority if (cv_q[FRAC_BITS].zero) begin
      s_m = '0;
    end else if (cv_q[FRAC_BITS].full) begin
      s_m = ONE_S;
    end else begin
      s_m = {1'b0, cv_q[FRAC_BITS].q};
    end
    abs_m = cv_q[FRAC_BITS].c[AX_W-1] ? AX_W'(-cv_q[FRAC_BITS].c)
                                      : AX_W'(cv_q[FRAC_BITS].c);
    p_m   = PROD_W'(abs_m) * PROD_W'(s_m);
  end

  always_ff @(posedge clk_i) begin
    dv_q[0].radial <= cv_q[FRAC_BITS].radial;
    dv_q[0].c      <= cv_q[FRAC_BITS].c;
    dv_q[0].s      <= s_m;
    dv_q[0].mag    <= cv_q[FRAC_BITS].mag;
    dv_q[0].p      <= p_m;
    dv_q[0].rem    <= DREM_W'(p_m[PROD_W-1:Q_W]);
    dv_q[0].q      <= '0;
  end

  // restoring division of |c| * s by the vector magnitude
  for (genvar k = 0; k < Q_W; k++) begin : g_scale
    logic [DREM_W-1:0] sh;
    assign sh = {dv_q[k].rem[DREM_W-2:0], dv_q[k].p[Q_W-1-k]};

    always_ff @(posedge clk_i) begin
      dv_q[k+1].radial <= dv_q[k].radial;
      dv_q[k+1].c      <= dv_q[k].c;
      dv_q[k+1].s      <= dv_q[k].s;
      dv_q[k+1].mag    <= dv_q[k].mag;
      dv_q[k+1].p      <= dv_q[k].p;
      if (sh >= {1'b0, dv_q[k].mag}) begin
        dv_q[k+1].rem <= sh - {1'b0, dv_q[k].mag};
        dv_q[k+1].q   <= {dv_q[k].q[Q_W-2:0], 1'b1};
      end else begin
        dv_q[k+1].rem <= sh;
        dv_q[k+1].q   <= {dv_q[k].q[Q_W-2:0], 1'b0};
      end
    end
  end

  logic signed [AX_W-1:0] ext_f;
  logic signed [AX_W-1:0] res_d;

  always_comb begin
    ext_f = $signed(AX_W'(dv_q[Q_W].radial ? dv_q[Q_W].q : dv_q[Q_W].s));
    if (dv_q[Q_W].c == '0) begin
      res_d = '0;
    end else if (dv_q[Q_W].c[AX_W-1]) begin
      res_d = -ext_f;
    end else begin
      res_d = ext_f;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// File: sv/stick_dead_zone_scaler.sv
// Top level: stick dead-zone scaler with shared root and three axis lanes.
//
//  port group       dir  handshake         contents
//  item in          in   start / busy      value_kind_i, axis_x_i, axis_y_i, axis_z_i
//  result out       out  done_o strobe     out_x_o, out_y_o, out_z_o
//  register write   in   cfg_we_i          cfg_idx_i, cfg_data_i
//
//  One item per cycle; busy stays low, so start is taken on every cycle.
//  Each result passes through registered steps in order: squares, sum, 16 root
//  stages, threshold check, 14 curve divide steps, product, 15 scale divide
//  steps, sign restore and merge.
//  done_o is high for one cycle per item; the receiver cannot stall.
//  Reset clears the valid pipe and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module stick_dead_zone_scaler
  import sdz_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             value_kind_i,
  input  wire logic signed [AX_W-1:0] axis_x_i,
  input  wire logic signed [AX_W-1:0] axis_y_i,
  input  wire logic signed [AX_W-1:0] axis_z_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  output logic                        done_o,
  output logic signed [AX_W-1:0]      out_x_o,
  output logic signed [AX_W-1:0]      out_y_o,
  output logic signed [AX_W-1:0]      out_z_o
);

  localparam logic signed [AX_W-1:0] ONE_A = $signed(AX_W'(ONE_S));

  logic [CFG_W-1:0] dz_low_q, upper_q;
  logic             mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_low_q <= DZ_LOW_RST;
      upper_q  <= UPPER_RST;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DZ_LOW: dz_low_q <= cfg_data_i;
        REG_UPPER:  upper_q  <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  logic [CFG_W-1:0] lower;
  assign lower = (dz_low_q > ONE_C) ? ONE_C : dz_low_q;

  logic acc;
  assign busy = 1'b0;
  assign acc  = start && !busy;

  logic [META_LEN:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[META_LEN-1:0], acc};
    end
  end

  item_t                  meta_q [META_LEN];
  logic [SQ_W-1:0]        sq_x_q, sq_y_q, sq_z_q, sum_q;
  logic signed [AX_W-1:0] z_sel;
  logic signed [SQ_W-1:0] px, py, pz;

  always_comb begin
    z_sel = (value_kind_i == KIND_3D) ? axis_z_i : '0;
    px    = SQ_W'(axis_x_i) * SQ_W'(axis_x_i);
    py    = SQ_W'(axis_y_i) * SQ_W'(axis_y_i);
    pz    = SQ_W'(z_sel) * SQ_W'(z_sel);
  end

  always_ff @(posedge clk_i) begin
    meta_q[0].kind   <= kind_e'(value_kind_i);
    meta_q[0].radial <= mode_q && value_kind_i[1];
    meta_q[0].x      <= axis_x_i;
    meta_q[0].y      <= axis_y_i;
    meta_q[0].z      <= axis_z_i;
    sq_x_q           <= $unsigned(px);
    sq_y_q           <= $unsigned(py);
    sq_z_q           <= $unsigned(pz);
    sum_q            <= sq_x_q + sq_y_q + sq_z_q;
    for (int i = 1; i < META_LEN; i++) begin
      meta_q[i] <= meta_q[i-1];
    end
  end

  logic [RT_W-1:0] root;

  sdz_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sum_q),
    .root_o (root)
  );

  logic signed [AX_W-1:0] lane_c   [3];
  logic signed [AX_W-1:0] lane_res [3];

  assign lane_c[0] = meta_q[TAP].x;
  assign lane_c[1] = meta_q[TAP].y;
  assign lane_c[2] = meta_q[TAP].z;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    sdz_lane u_lane (
      .clk_i    (clk_i),
      .radial_i (meta_q[TAP].radial),
      .c_i      (lane_c[l]),
      .mag_i    (root),
      .lower_i  (lower),
      .upper_i  (upper_q),
      .res_o    (lane_res[l])
    );
  end

  // merge: pass-through for boolean items, zero for unused axes
  logic signed [AX_W-1:0] out_x_q, out_y_q, out_z_q;
  item_t                  mm;
  assign mm = meta_q[META_LEN-1];

  always_ff @(posedge clk_i) begin
    unique case (mm.kind)
      KIND_BOOL: begin
        out_x_q <= mm.x;
        out_y_q <= mm.y;
        out_z_q <= mm.z;
      end
      KIND_1D: begin
        out_x_q <= lane_res[0];
        out_y_q <= '0;
        out_z_q <= '0;
      end
      KIND_2D: begin
        out_x_q <= lane_res[0];
        out_y_q <= lane_res[1];
        out_z_q <= '0;
      end
      KIND_3D: begin
        out_x_q <= lane_res[0];
        out_y_q <= lane_res[1];
        out_z_q <= lane_res[2];
      end
      default: begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_z_q <= '0;
      end
    endcase
  end

  assign done_o  = vld_q[META_LEN];
  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(META_LEN+1) done_o)
    else $error("item result missing at fixed latency");

  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[META_LEN-1] && mm.kind == KIND_1D |=> out_y_o == '0 && out_z_o == '0)
    else $error("unused axes not cleared");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[META_LEN-1] && mm.kind != KIND_BOOL && mm.x == '0 && mm.y == '0 && mm.z == '0
    |=> out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("zero vector gave nonzero output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[META_LEN-1] && mm.kind != KIND_BOOL
    |-> lane_res[0] <= ONE_A && lane_res[0] >= -ONE_A)
    else $error("lane output beyond full scale");
`endif

endmodule
`default_nettype wire
